FILE: src/sorted_index_list_by_key_defines.svh
// Assertion macros shared by the sorted index list files.
`ifndef SORTED_INDEX_LIST_BY_KEY_DEFINES_SVH
`define SORTED_INDEX_LIST_BY_KEY_DEFINES_SVH

// Checks that a condition in one cycle implies a condition in the next cycle.
`define SIL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks that a condition implies another condition in the same cycle.
`define SIL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/sil_pkg.sv
// Shared codes, port widths and control structures of the sorted index list.
package sil_pkg;

    // Port widths fixed by the interface.
    localparam int MODE_W    = 2;
    localparam int IN_KEY_W  = 32;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_KEY_W = 32;
    localparam int STS_W     = 2;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clear_cnt;   // empty the list
        logic             start_add;   // latch key, set insert pointer, read last entry
        logic             shift_step;  // move one entry up, read the next lower one
        logic             place;       // write the new node and present its result
        logic             resp;        // present a full or empty status result
        logic [STS_W-1:0] resp_status; // status code used by resp
        logic             rd_start;    // reset the read stream pointers
        logic             rd_run;      // stream entries to the output
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;  // list is empty
        logic full;      // list holds CAPACITY entries
        logic greater;   // entry just read has a larger key than the new one
        logic pos_one;   // insert pointer is at position one
        logic out_free;  // output register can take a result this cycle
        logic rd_fin;    // final entry of a read is loaded this cycle
    } t_dp_sts;

endpackage

FILE: src/sil_ctrl.sv
// Controller state machine of the sorted index list.
module sil_ctrl
    import sil_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_stall,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_RESP  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [STS_W-1:0] r_resp_sts;
    logic [STS_W-1:0] n_resp_sts;

    // Requests are taken only while no earlier request is in progress.
    assign o_stall = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_resp_sts = r_resp_sts;
        o_cmd      = '0;
        o_cmd.resp_status = r_resp_sts;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        MODE_ADD: begin
                            if (i_sts.full) begin
                                n_resp_sts = STS_FULL;
                                n_state    = S_RESP;
                            end else begin
                                o_cmd.start_add = 1'b1;
                                n_state = i_sts.cnt_zero ? S_PLACE : S_SHIFT;
                            end
                        end
                        MODE_READ: begin
                            if (i_sts.cnt_zero) begin
                                n_resp_sts = STS_EMPTY;
                                n_state    = S_RESP;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                                n_state        = S_READ;
                            end
                        end
                        MODE_CLEAR: begin
                            o_cmd.clear_cnt = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Move larger keys up until the insert place is found.
                if (i_sts.greater) begin
                    o_cmd.shift_step = 1'b1;
                    if (i_sts.pos_one) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (i_sts.out_free) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_run = 1'b1;
                if (i_sts.rd_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_resp_sts <= STS_OK;
        end else begin
            r_state    <= n_state;
            r_resp_sts <= n_resp_sts;
        end
    end

endmodule

FILE: src/sil_dp.sv
// Datapath of the sorted index list: entry memory, pointers and result register.
module sil_dp
    import sil_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IN_KEY_W-1:0]  i_key,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [OUT_IDX_W-1:0] o_node_index,
    output logic [OUT_KEY_W-1:0] o_node_key,
    output logic [OUT_IDX_W-1:0] o_rank,
    output logic                 o_last,
    output logic [STS_W-1:0]     o_status,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry memory: node indices and keys in ascending key order.
    logic [AW-1:0]       mem_idx [CAPACITY];
    logic [KEY_BITS-1:0] mem_key [CAPACITY];

    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_pos;
    logic [KEY_BITS-1:0] r_key;
    logic [AW-1:0]       r_rd_idx;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [CW-1:0]       r_rptr;
    logic [AW-1:0]       r_rank_rd;
    logic                r_pend;

    logic                r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [OUT_KEY_W-1:0] r_out_key;
    logic [OUT_IDX_W-1:0] r_out_rank;
    logic                r_out_last;
    logic [STS_W-1:0]    r_out_sts;

    logic                out_free;
    logic                rd_load;
    logic                rd_issue;
    logic                rd_last;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_idx;
    logic [KEY_BITS-1:0] wr_key;

    assign out_free = !r_out_valid || !i_stall;

    // Read streaming: one entry moves from the memory register to the output per cycle while the output is not stalled.
    assign rd_last  = (r_rank_rd == AW'(r_count - CW'(1)));
    assign rd_load  = i_cmd.rd_run && r_pend && out_free;
    assign rd_issue = i_cmd.rd_run && (r_rptr != r_count) && (!r_pend || rd_load);

    // Memory read port address select.
    always_comb begin
        rd_en   = i_cmd.start_add || i_cmd.shift_step || rd_issue;
        rd_addr = r_rptr[AW-1:0];
        if (i_cmd.start_add) begin
            rd_addr = AW'(r_count - CW'(1));
        end else if (i_cmd.shift_step) begin
            rd_addr = r_pos - AW'(2);
        end
    end

    // Memory write port: either a shifted entry or the new node.
    assign wr_en  = i_cmd.shift_step || i_cmd.place;
    assign wr_idx = i_cmd.shift_step ? r_rd_idx : r_count[AW-1:0];
    assign wr_key = i_cmd.shift_step ? r_rd_key : r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_idx[r_pos] <= wr_idx;
            mem_key[r_pos] <= wr_key;
        end
        if (rd_en) begin
            r_rd_idx <= mem_idx[rd_addr];
            r_rd_key <= mem_key[rd_addr];
        end
    end

    // Key and insert pointer of the node being added, and rank of the entry read for streaming.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_add) begin
            r_key <= KEY_BITS'(i_key);
            r_pos <= r_count[AW-1:0];
        end else if (i_cmd.shift_step) begin
            r_pos <= r_pos - AW'(1);
        end
        if (rd_issue) begin
            r_rank_rd <= r_rptr[AW-1:0];
        end
    end

    // Entry count and read stream control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rptr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.clear_cnt) begin
                r_count <= '0;
            end else if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.rd_start) begin
                r_rptr <= '0;
                r_pend <= 1'b0;
            end else begin
                if (rd_issue) begin
                    r_rptr <= r_rptr + CW'(1);
                end
                if (rd_issue) begin
                    r_pend <= 1'b1;
                end else if (rd_load) begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.place || i_cmd.resp || rd_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_out_idx  <= OUT_IDX_W'(r_count[AW-1:0]);
            r_out_key  <= OUT_KEY_W'(r_key);
            r_out_rank <= OUT_IDX_W'(r_pos);
            r_out_last <= 1'b1;
            r_out_sts  <= STS_OK;
        end else if (i_cmd.resp) begin
            r_out_idx  <= '0;
            r_out_key  <= '0;
            r_out_rank <= '0;
            r_out_last <= 1'b1;
            r_out_sts  <= i_cmd.resp_status;
        end else if (rd_load) begin
            r_out_idx  <= OUT_IDX_W'(r_rd_idx);
            r_out_key  <= OUT_KEY_W'(r_rd_key);
            r_out_rank <= OUT_IDX_W'(r_rank_rd);
            r_out_last <= rd_last;
            r_out_sts  <= STS_OK;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_node_index = r_out_idx;
    assign o_node_key   = r_out_key;
    assign o_rank       = r_out_rank;
    assign o_last       = r_out_last;
    assign o_status     = r_out_sts;

    // Status toward the controller.
    always_comb begin
        o_sts          = '0;
        o_sts.cnt_zero = (r_count == '0);
        o_sts.full     = (r_count == CW'(CAPACITY));
        o_sts.greater  = (r_rd_key > r_key);
        o_sts.pos_one  = (r_pos == AW'(1));
        o_sts.out_free = out_free;
        o_sts.rd_fin   = rd_load && rd_last;
    end

endmodule

FILE: src/sorted_index_list_by_key.sv
// Top level of the sorted index list keyed by path cost.
//
// Usage: a request carries i_mode and i_key on i_valid; the block pushes back with
// o_stall while a request is in progress. Mode add places a new node, which takes
// the next free index, after all entries with an equal or smaller key and returns
// one result with its index, key and rank, or status full when CAPACITY nodes are
// held. Mode read streams every entry in ascending key order with o_last on the
// final one, or one empty-status result. Mode clear empties the list with no result.
// Results leave on o_valid and are held unchanged while i_stall is high.
// Operation: an add reads the last entry, then moves each held entry with a larger
// key up one place, one entry per cycle through the single write port of the entry
// memory, then writes the new node and presents its result; with an empty list it
// writes at once. A full or empty status result waits for a free output register.
// A read streams one entry per cycle while the receiver does not stall, set by the
// one memory read port. A clear leaves the block ready in the next cycle. A stalled
// receiver stops the read stream and holds the add result; the next request is
// taken once the final result of a request sits in the output register.
// Reset empties the list and the output register; entry memory is not cleared.
`include "sorted_index_list_by_key_defines.svh"

module sorted_index_list_by_key
    import sil_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [IN_KEY_W-1:0]  i_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_IDX_W-1:0] o_node_index,
    output logic [OUT_KEY_W-1:0] o_node_key,
    output logic [OUT_IDX_W-1:0] o_rank,
    output logic                 o_last,
    output logic [STS_W-1:0]     o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller.
    sil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath.
    sil_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_node_index (o_node_index),
        .o_node_key   (o_node_key),
        .o_rank       (o_rank),
        .o_last       (o_last),
        .o_status     (o_status),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

    // A clear leaves the block ready in the next cycle.
    `SIL_ASSERT_NEXT(a_clear_one_cycle, i_valid && !o_stall && i_mode == MODE_CLEAR, !o_stall, "clear request did not complete in one cycle")

    // Add and read requests always keep the block busy in the next cycle.
    `SIL_ASSERT_NEXT(a_add_read_busy, i_valid && !o_stall && (i_mode == MODE_ADD || i_mode == MODE_READ), o_stall, "add or read request did not hold off the next request")

    // Full and empty results are single results with zero index and rank.
    `SIL_ASSERT_NOW(a_error_result_form, o_valid && o_status != STS_OK, o_last && o_rank == '0 && o_node_index == '0 && o_node_key == '0, "status result with unexpected payload")

endmodule
